// File: hdl/tdsas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tdsas_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned INSTR_W   = 16;
    localparam int unsigned NUM_REGS  = 8;
    localparam int unsigned REG_IDX_W = $clog2(NUM_REGS);
    localparam int unsigned FMT_W     = 5;

    typedef logic [FMT_W-1:0]     t_fmt;
    typedef logic [INSTR_W-1:0]   t_instr;
    typedef logic [DATA_W-1:0]    t_word;
    typedef logic [REG_IDX_W-1:0] t_reg_idx;

    localparam t_fmt FMT_NONE          = 5'd0;
    localparam t_fmt FMT_MOVE_SHIFTED  = 5'd1;
    localparam t_fmt FMT_ADD_SUB       = 5'd2;
    localparam t_fmt FMT_IMM           = 5'd3;
    localparam t_fmt FMT_ALU           = 5'd4;
    localparam t_fmt FMT_HI_REG        = 5'd5;
    localparam t_fmt FMT_PC_LOAD       = 5'd6;
    localparam t_fmt FMT_LS_REG        = 5'd7;
    localparam t_fmt FMT_LS_SIGN       = 5'd8;
    localparam t_fmt FMT_LS_IMM        = 5'd9;
    localparam t_fmt FMT_LS_HALF       = 5'd10;
    localparam t_fmt FMT_SP_LS         = 5'd11;
    localparam t_fmt FMT_LOAD_ADDR     = 5'd12;
    localparam t_fmt FMT_SP_ADD        = 5'd13;
    localparam t_fmt FMT_PUSH_POP      = 5'd14;
    localparam t_fmt FMT_MULTI_LS      = 5'd15;
    localparam t_fmt FMT_COND_BRANCH   = 5'd16;
    localparam t_fmt FMT_SWI           = 5'd17;
    localparam t_fmt FMT_BRANCH        = 5'd18;
    localparam t_fmt FMT_LONG_BRANCH   = 5'd19;

    typedef enum logic [1:0] {
        SH_LSL = 2'd0,
        SH_LSR = 2'd1,
        SH_ASR = 2'd2
    } t_shift_op;

    typedef enum logic [1:0] {
        IMM_MOV = 2'd0,
        IMM_CMP = 2'd1,
        IMM_ADD = 2'd2,
        IMM_SUB = 2'd3
    } t_imm_op;

    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } t_flags;

    typedef struct packed {
        t_fmt     format_class;
        logic     executed;
        logic     wrote_register;
        t_reg_idx dest_index;
        t_word    dest_value;
        t_flags   flags;
    } t_result;

    // Formats are tested in ascending order and the first match wins.
    function automatic t_fmt tdsas_classify(input t_instr w);
        t_fmt f;
        priority if ((w & 16'hF800) <  16'h1800) f = FMT_MOVE_SHIFTED;
        else if ((w & 16'hF800) == 16'h1800) f = FMT_ADD_SUB;
        else if ((w & 16'hE000) == 16'h2000) f = FMT_IMM;
        else if ((w & 16'hFC00) == 16'h4000) f = FMT_ALU;
        else if ((w & 16'hFC00) == 16'h4400) f = FMT_HI_REG;
        else if ((w & 16'hF800) == 16'h4800) f = FMT_PC_LOAD;
        else if ((w & 16'hF200) == 16'h5000) f = FMT_LS_REG;
        else if ((w & 16'hF200) == 16'h5200) f = FMT_LS_SIGN;
        else if ((w & 16'hE000) == 16'h6000) f = FMT_LS_IMM;
        else if ((w & 16'hF000) == 16'h8000) f = FMT_LS_HALF;
        else if ((w & 16'hF000) == 16'h9000) f = FMT_SP_LS;
        else if ((w & 16'hF000) == 16'hA000) f = FMT_LOAD_ADDR;
        else if ((w & 16'hFF00) == 16'hB000) f = FMT_SP_ADD;
        else if ((w & 16'hF600) == 16'hB400) f = FMT_PUSH_POP;
        else if ((w & 16'hF000) == 16'hC000) f = FMT_MULTI_LS;
        else if ((w & 16'hF000) == 16'hD000) f = FMT_COND_BRANCH;
        else if ((w & 16'hFF00) == 16'hDF00) f = FMT_SWI;
        else if ((w & 16'hF800) == 16'hE000) f = FMT_BRANCH;
        else if ((w & 16'hF000) == 16'hF000) f = FMT_LONG_BRANCH;
        else f = FMT_NONE;
        return f;
    endfunction

endpackage

`default_nettype wire

// File: hdl/tdsas_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tdsas_in_if;
    logic                  valid;
    logic                  ready;
    tdsas_pkg::t_instr     instruction;

    modport source (output valid, output instruction, input ready);
    modport sink   (input valid, input instruction, output ready);
endinterface

interface tdsas_out_if;
    logic                  valid;
    logic                  ready;
    tdsas_pkg::t_fmt       format_class;
    logic                  executed;
    logic                  wrote_register;
    tdsas_pkg::t_reg_idx   dest_index;
    tdsas_pkg::t_word      dest_value;
    logic                  flag_n;
    logic                  flag_z;
    logic                  flag_c;
    logic                  flag_v;

    modport source (
        output valid, output format_class, output executed, output wrote_register,
        output dest_index, output dest_value, output flag_n, output flag_z,
        output flag_c, output flag_v, input ready
    );
    modport sink (
        input valid, input format_class, input executed, input wrote_register,
        input dest_index, input dest_value, input flag_n, input flag_z,
        input flag_c, input flag_v, output ready
    );
endinterface

`default_nettype wire

// File: hdl/tdsas_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tdsas_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]              o_rd_data_a,
    output logic [WIDTH-1:0]              o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // A read at the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data_a <= r_mem[i_rd_addr_a];
            o_rd_data_b <= r_mem[i_rd_addr_b];
        end
    end

endmodule

`default_nettype wire

// File: hdl/tdsas_regfile.sv
`timescale 1ns / 1ps
`default_nettype none

module tdsas_regfile (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_rd_en,
    input  wire tdsas_pkg::t_reg_idx  i_rd_addr_a,
    input  wire tdsas_pkg::t_reg_idx  i_rd_addr_b,
    input  wire logic                 i_wr_en,
    input  wire tdsas_pkg::t_reg_idx  i_wr_addr,
    input  wire tdsas_pkg::t_word     i_wr_data,
    output tdsas_pkg::t_word          o_rd_data_a,
    output tdsas_pkg::t_word          o_rd_data_b
);

    import tdsas_pkg::*;

    t_word    ram_data_a;
    t_word    ram_data_b;
    logic     r_written [NUM_REGS];
    logic     r_valid_a;
    logic     r_valid_b;
    t_reg_idx r_addr_a;
    t_reg_idx r_addr_b;
    logic     r_fwd_en;
    t_reg_idx r_fwd_addr;
    t_word    r_fwd_data;

    tdsas_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_REGS)
    ) u_ram (
        .i_clk       (i_clk),
        .i_wr_en     (i_wr_en),
        .i_wr_addr   (i_wr_addr),
        .i_wr_data   (i_wr_data),
        .i_rd_en     (i_rd_en),
        .i_rd_addr_a (i_rd_addr_a),
        .i_rd_addr_b (i_rd_addr_b),
        .o_rd_data_a (ram_data_a),
        .o_rd_data_b (ram_data_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_written[i] <= 1'b0;
            end
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
            r_fwd_en  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_written[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_valid_a <= r_written[i_rd_addr_a];
                r_valid_b <= r_written[i_rd_addr_b];
                r_fwd_en  <= i_wr_en;
            end
        end
    end

    // A write that lands on the same edge as the read is forwarded afterward.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_addr_a   <= i_rd_addr_a;
            r_addr_b   <= i_rd_addr_b;
            r_fwd_addr <= i_wr_addr;
            r_fwd_data <= i_wr_data;
        end
    end

    always_comb begin
        if (r_fwd_en && (r_fwd_addr == r_addr_a)) begin
            o_rd_data_a = r_fwd_data;
        end else if (r_valid_a) begin
            o_rd_data_a = ram_data_a;
        end else begin
            o_rd_data_a = '0;
        end
        if (r_fwd_en && (r_fwd_addr == r_addr_b)) begin
            o_rd_data_b = r_fwd_data;
        end else if (r_valid_b) begin
            o_rd_data_b = ram_data_b;
        end else begin
            o_rd_data_b = '0;
        end
    end

endmodule

`default_nettype wire

// File: hdl/tdsas_alu.sv
`timescale 1ns / 1ps
`default_nettype none

module tdsas_alu (
    input  wire tdsas_pkg::t_instr  i_instr,
    input  wire tdsas_pkg::t_word   i_op_a,
    input  wire tdsas_pkg::t_word   i_op_b,
    input  wire tdsas_pkg::t_flags  i_flags,
    output tdsas_pkg::t_result      o_result
);

    import tdsas_pkg::*;

    t_fmt        fmt;
    logic [4:0]  sh_amt;
    logic [32:0] lsl_ext;
    logic [32:0] lsr_ext;
    logic [32:0] asr_ext;
    t_word       b_sel;
    logic [32:0] sum_ext;
    logic [32:0] diff_ext;
    logic        add_v;
    logic        sub_v;
    t_word       val;

    assign fmt     = tdsas_classify(i_instr);
    assign sh_amt  = i_instr[10:6];
    assign lsl_ext = {1'b0, i_op_a} << sh_amt;
    assign lsr_ext = {i_op_a, 1'b0} >> sh_amt;
    assign asr_ext = $signed({i_op_a, 1'b0}) >>> sh_amt;

    always_comb begin
        if (fmt == FMT_IMM) begin
            b_sel = {24'd0, i_instr[7:0]};
        end else if (i_instr[10]) begin
            b_sel = {29'd0, i_instr[8:6]};
        end else begin
            b_sel = i_op_b;
        end
    end

    assign sum_ext  = {1'b0, i_op_a} + {1'b0, b_sel};
    assign diff_ext = {1'b0, i_op_a} + {1'b0, ~b_sel} + 33'd1;
    assign add_v    = ~(i_op_a[31] ^ b_sel[31]) & (i_op_a[31] ^ sum_ext[31]);
    assign sub_v    = (i_op_a[31] ^ b_sel[31]) & (i_op_a[31] ^ diff_ext[31]);

    always_comb begin
        o_result                = '0;
        o_result.format_class   = fmt;
        o_result.flags          = i_flags;
        val                     = '0;
        if (fmt == FMT_MOVE_SHIFTED) begin
            unique case (t_shift_op'(i_instr[12:11]))
                SH_LSL: begin
                    val = lsl_ext[31:0];
                    if (sh_amt != 5'd0) begin
                        o_result.flags.c = lsl_ext[32];
                    end
                end
                SH_LSR: begin
                    if (sh_amt == 5'd0) begin
                        val = '0;
                        o_result.flags.c = i_op_a[31];
                    end else begin
                        val = lsr_ext[32:1];
                        o_result.flags.c = lsr_ext[0];
                    end
                end
                SH_ASR: begin
                    if (sh_amt == 5'd0) begin
                        val = {DATA_W{i_op_a[31]}};
                        o_result.flags.c = i_op_a[31];
                    end else begin
                        val = asr_ext[32:1];
                        o_result.flags.c = asr_ext[0];
                    end
                end
                default: begin
                    val = i_op_a;
                end
            endcase
            o_result.flags.n        = val[31];
            o_result.flags.z        = (val == '0);
            o_result.executed       = 1'b1;
            o_result.wrote_register = 1'b1;
            o_result.dest_index     = i_instr[2:0];
        end else if (fmt == FMT_ADD_SUB) begin
            if (i_instr[9]) begin
                val = diff_ext[31:0];
                o_result.flags.c = diff_ext[32];
                o_result.flags.v = sub_v;
            end else begin
                val = sum_ext[31:0];
                o_result.flags.c = sum_ext[32];
                o_result.flags.v = add_v;
            end
            o_result.flags.n        = val[31];
            o_result.flags.z        = (val == '0);
            o_result.executed       = 1'b1;
            o_result.wrote_register = 1'b1;
            o_result.dest_index     = i_instr[2:0];
        end else if (fmt == FMT_IMM) begin
            unique case (t_imm_op'(i_instr[12:11]))
                IMM_MOV: begin
                    val = b_sel;
                    o_result.wrote_register = 1'b1;
                end
                IMM_CMP: begin
                    val = diff_ext[31:0];
                    o_result.flags.c = diff_ext[32];
                    o_result.flags.v = sub_v;
                end
                IMM_ADD: begin
                    val = sum_ext[31:0];
                    o_result.flags.c = sum_ext[32];
                    o_result.flags.v = add_v;
                    o_result.wrote_register = 1'b1;
                end
                IMM_SUB: begin
                    val = diff_ext[31:0];
                    o_result.flags.c = diff_ext[32];
                    o_result.flags.v = sub_v;
                    o_result.wrote_register = 1'b1;
                end
            endcase
            o_result.flags.n    = val[31];
            o_result.flags.z    = (val == '0);
            o_result.executed   = 1'b1;
            o_result.dest_index = i_instr[10:8];
        end
        o_result.dest_value = val;
    end

endmodule

`default_nettype wire

// File: hdl/thumb_decode_shift_add_sub.sv
`timescale 1ns / 1ps
`default_nettype none

// Classifies one 16-bit Thumb instruction per transaction into its format
// number and executes the shift, add/subtract and 8-bit immediate formats on
// eight 32-bit low registers and the N, Z, C and V flags. The block accepts
// one transaction per clock cycle unless the output stalls: the register
// file read is registered on acceptance, and the shifter or adder, the
// register write-back and the flag update complete as the instruction moves
// into the output register, with the value just written forwarded to the
// following instruction. The registers read as zero after reset without a
// clearing pass. An output register decouples the result from further
// transactions, so a stalled consumer only holds the pipeline once both
// stages are full.
module thumb_decode_shift_add_sub (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tdsas_in_if.sink    i_in,
    tdsas_out_if.source o_out
);

    import tdsas_pkg::*;

    logic     in_fire;
    logic     s1_go;
    logic     r_s1_valid;
    t_instr   r_instr;
    t_word    op_a;
    t_word    op_b;
    t_reg_idx rd_addr_a;
    t_flags   r_flags;
    t_result  alu_result;
    logic     r_out_valid;
    t_result  r_out;

    assign s1_go      = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_go;
    assign in_fire    = i_in.valid && i_in.ready;

    // The 8-bit immediate format names its register in bits 10 to 8.
    assign rd_addr_a = (i_in.instruction[15:13] == 3'b001) ? i_in.instruction[10:8]
                                                            : i_in.instruction[5:3];

    tdsas_regfile u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (in_fire),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (i_in.instruction[8:6]),
        .i_wr_en     (s1_go && alu_result.wrote_register),
        .i_wr_addr   (alu_result.dest_index),
        .i_wr_data   (alu_result.dest_value),
        .o_rd_data_a (op_a),
        .o_rd_data_b (op_b)
    );

    tdsas_alu u_alu (
        .i_instr  (r_instr),
        .i_op_a   (op_a),
        .i_op_b   (op_b),
        .i_flags  (r_flags),
        .o_result (alu_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= '0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go) begin
                r_out_valid <= 1'b1;
                r_flags     <= alu_result.flags;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_instr <= i_in.instruction;
        end
        if (s1_go) begin
            r_out <= alu_result;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.format_class   = r_out.format_class;
    assign o_out.executed       = r_out.executed;
    assign o_out.wrote_register = r_out.wrote_register;
    assign o_out.dest_index     = r_out.dest_index;
    assign o_out.dest_value     = r_out.dest_value;
    assign o_out.flag_n         = r_out.flags.n;
    assign o_out.flag_z         = r_out.flags.z;
    assign o_out.flag_c         = r_out.flags.c;
    assign o_out.flag_v         = r_out.flags.v;

endmodule

`default_nettype wire
